FILE: rtl/sparse_projection_hebbian_engine_top_macros.svh
// Assertion macros shared by the sparse projection engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SPARSE_PROJECTION_HEBBIAN_ENGINE_TOP_MACROS_SVH
`define SPARSE_PROJECTION_HEBBIAN_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPHENG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPHENG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/spheng_pkg.sv
// Package of the sparse projection engine: sizes, codes, types and clamp helpers.
// Depends on nothing; used by the divider and the top level of the engine.
package spheng_pkg;

   localparam int SRC_UNITS     = 1024;
   localparam int COL_UNITS     = 1024;
   localparam int FRACTION_BITS = 24;

   localparam int VAL_W  = 32;
   localparam int SUM_W  = 48;
   localparam int MODE_W = 3;
   localparam int IDX_W  = 10;
   localparam int THR_W  = 31;

   localparam int SRC_AW    = $clog2(SRC_UNITS);
   localparam int COL_AW    = $clog2(COL_UNITS);
   localparam int ACT_DEPTH = SRC_UNITS + COL_UNITS;
   localparam int ACT_AW    = $clog2(ACT_DEPTH);
   localparam int COL_MEM_W = 2 * SUM_W;

   localparam int NUM_W     = VAL_W + FRACTION_BITS;
   localparam int DEN_W     = SUM_W;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam int SPLIT  = SUM_W / 2;
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int WIDE_W = 84;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_LOAD_SRC  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_DST  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PROJECT   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_LEARN     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_TOTAL     = 3'd5;
   localparam logic [MODE_W-1:0] MODE_NORMALIZE = 3'd6;
   localparam logic [MODE_W-1:0] MODE_READ      = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_GAIN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_ENABLE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_THRESHOLD = 2'd3;

   localparam logic signed [VAL_W-1:0] GAIN_RESET = VAL_W'(64'sd1 <<< FRACTION_BITS);
   localparam logic [THR_W-1:0]        THR_RESET  = 31'd17;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic fits_val(input logic signed [WIDE_W-1:0] x);
      return (&x[WIDE_W-1:VAL_W-1]) || (~|x[WIDE_W-1:VAL_W-1]);
   endfunction

   function automatic logic signed [VAL_W-1:0] clamp_val(input logic signed [WIDE_W-1:0] x);
      logic signed [VAL_W-1:0] r;
      if (fits_val(x)) r = x[VAL_W-1:0];
      else             r = x[WIDE_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      return r;
   endfunction

   function automatic logic fits_sum(input logic signed [WIDE_W-1:0] x);
      return (&x[WIDE_W-1:SUM_W-1]) || (~|x[WIDE_W-1:SUM_W-1]);
   endfunction

   function automatic logic signed [SUM_W-1:0] clamp_sum(input logic signed [WIDE_W-1:0] x);
      logic signed [SUM_W-1:0] r;
      if (fits_sum(x)) r = x[SUM_W-1:0];
      else             r = x[WIDE_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      return r;
   endfunction

endpackage

FILE: rtl/spheng_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module spheng_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/spheng_div.sv
// Restoring divider of unsigned magnitudes, one quotient bit per cycle.
// Depends on spheng_pkg.
module spheng_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [spheng_pkg::NUM_W-1:0]     num_mag,
   input  logic [spheng_pkg::DEN_W-1:0]     den_mag,
   output logic [spheng_pkg::NUM_W-1:0]     quotient,
   output spheng_pkg::div_status_type       status
);

   logic [spheng_pkg::NUM_W-1:0]     q_ff;
   logic [spheng_pkg::DEN_W:0]       rem_ff;
   logic [spheng_pkg::DEN_W-1:0]     den_ff;
   logic [spheng_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                             busy_ff;
   logic                             done_ff;

   logic [spheng_pkg::DEN_W:0]       rem_sh;
   logic                             ge;
   logic [spheng_pkg::DEN_W:0]       rem_in;
   logic [spheng_pkg::NUM_W-1:0]     q_in;

   always_comb begin
      rem_sh = {rem_ff[spheng_pkg::DEN_W-1:0], q_ff[spheng_pkg::NUM_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      q_in   = {q_ff[spheng_pkg::NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff &&
                      cnt_ff == spheng_pkg::DIV_CNT_W'(spheng_pkg::NUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num_mag;
         rem_ff <= '0;
         den_ff <= den_mag;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign quotient    = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: rtl/sparse_projection_hebbian_engine_top.sv
// Top level of the sparse projection and Hebbian learning engine.
// Depends on spheng_pkg, spheng_ram, spheng_div and the assertion macro header.
//
//   Channel   Handshake             Payload
//   request   start / busy          req_mode, req_row_index, req_column_index,
//                                   req_item_value
//   response  rsp_valid (strobe)    rsp_result_value, rsp_total_value,
//                                   rsp_applied, rsp_error_flag
//   config    csr_wr_en             csr_index, csr_wr_data
//
// A beat is taken at a rising edge with start high and busy low. Every item walks
// the sequencer: two activity reads and one column read, two multiply steps with
// a clamp step between them, and a finish step that registers the response; the
// next beat may be taken in the cycle the result is shown. A normalize that has to
// divide runs the bit-serial divider in place of the clamp and second multiply
// steps. Reset is synchronous and active high; it clears the sequencer and the
// configuration registers but not the memories, which the user must load or clear
// before reads (the block does not check). The receiver cannot stall the response.
`include "sparse_projection_hebbian_engine_top_macros.svh"

module sparse_projection_hebbian_engine_top (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic [spheng_pkg::MODE_W-1:0]               req_mode,
   input  logic [spheng_pkg::IDX_W-1:0]                req_row_index,
   input  logic [spheng_pkg::IDX_W-1:0]                req_column_index,
   input  logic signed [spheng_pkg::VAL_W-1:0]         req_item_value,
   output logic                                        rsp_valid,
   output logic signed [spheng_pkg::VAL_W-1:0]         rsp_result_value,
   output logic signed [spheng_pkg::SUM_W-1:0]         rsp_total_value,
   output logic                                        rsp_applied,
   output logic                                        rsp_error_flag,
   input  logic                                        csr_wr_en,
   input  logic [spheng_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [spheng_pkg::CSR_DATA_W-1:0]           csr_wr_data
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RD_SRC = 4'd1;
   localparam logic [3:0] ST_RD_DST = 4'd2;
   localparam logic [3:0] ST_LOAD   = 4'd3;
   localparam logic [3:0] ST_MUL1   = 4'd4;
   localparam logic [3:0] ST_MID    = 4'd5;
   localparam logic [3:0] ST_MUL2   = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_FIN    = 4'd8;

   localparam int VW = spheng_pkg::VAL_W;
   localparam int SW = spheng_pkg::SUM_W;
   localparam int WW = spheng_pkg::WIDE_W;
   localparam int FB = spheng_pkg::FRACTION_BITS;

   logic [3:0] state_ff, state_in;

   // Configuration registers.
   logic signed [VW-1:0]                gain_ff;
   logic signed [VW-1:0]                lr_ff;
   logic                                gate_en_ff;
   logic [spheng_pkg::THR_W-1:0]        thr_ff;

   // Item and operand registers.
   logic [spheng_pkg::MODE_W-1:0]       mode_ff;
   logic [spheng_pkg::SRC_AW-1:0]       row_ff;
   logic [spheng_pkg::COL_AW-1:0]       col_ff;
   logic signed [VW-1:0]                w_ff;
   logic signed [VW-1:0]                src_ff;
   logic signed [VW-1:0]                dst_ff;
   logic signed [SW-1:0]                sum_ff;
   logic signed [SW-1:0]                tot_ff;
   logic signed [spheng_pkg::PROD_W-1:0] hi_ff;
   logic signed [spheng_pkg::PROD_W-1:0] lo_ff;
   logic signed [VW-1:0]                t_ff;
   logic                                terr_ff;

   // Response registers.
   logic                                rsp_valid_ff;
   logic signed [VW-1:0]                res_ff;
   logic signed [SW-1:0]                tot_out_ff;
   logic                                app_ff;
   logic                                err_ff;

   // Memories.
   logic                                act_wr_en;
   logic [spheng_pkg::ACT_AW-1:0]       act_wr_addr;
   logic [spheng_pkg::ACT_AW-1:0]       act_rd_addr;
   logic [VW-1:0]                       act_rd_data;
   logic                                col_wr_en;
   logic [spheng_pkg::COL_MEM_W-1:0]    col_wr_data;
   logic [spheng_pkg::COL_MEM_W-1:0]    col_rd_data;

   // Shared multiplier.
   logic signed [spheng_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [spheng_pkg::PROD_W-1:0] mul_p;

   // Divider.
   logic                                div_start;
   logic [spheng_pkg::NUM_W-1:0]        div_num;
   logic [spheng_pkg::DEN_W-1:0]        div_den;
   logic [spheng_pkg::NUM_W-1:0]        div_q;
   spheng_pkg::div_status_type          div_stat;

   // Gating decisions and finish-step results.
   logic                                src_low, dst_low;
   logic                                skip3, skip4, skip6, zero6, need_div;
   logic [VW-1:0]                       abs_w;
   logic [SW-1:0]                       abs_tot;
   logic signed [WW-1:0]                t_wide, x3, x4, tot4, x5, x7, x6;
   logic signed [VW-1:0]                nw;
   logic signed [spheng_pkg::NUM_W:0]   q_signed;
   logic signed [VW-1:0]                res_c;
   logic signed [SW-1:0]                tot_c, new_sum_c, new_tot_c;
   logic                                app_c, err_c;

   assign busy = (state_ff != ST_IDLE);

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= spheng_pkg::GAIN_RESET;
         lr_ff      <= '0;
         gate_en_ff <= 1'b0;
         thr_ff     <= spheng_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            spheng_pkg::CSR_OUTPUT_GAIN:    gain_ff    <= csr_wr_data[VW-1:0];
            spheng_pkg::CSR_LEARN_RATE:     lr_ff      <= csr_wr_data[VW-1:0];
            spheng_pkg::CSR_GATE_ENABLE:    gate_en_ff <= csr_wr_data[0];
            spheng_pkg::CSR_GATE_THRESHOLD: thr_ff     <= csr_wr_data[spheng_pkg::THR_W-1:0];
            default:                        gate_en_ff <= gate_en_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- memories
   // Source activities sit at the low addresses, destination activities above.
   assign act_rd_addr = (state_ff == ST_RD_SRC) ? spheng_pkg::ACT_AW'(row_ff)
                      : spheng_pkg::ACT_AW'(spheng_pkg::SRC_UNITS) + spheng_pkg::ACT_AW'(col_ff);
   assign act_wr_en   = (state_ff == ST_FIN) &&
                        (mode_ff == spheng_pkg::MODE_LOAD_SRC ||
                         mode_ff == spheng_pkg::MODE_LOAD_DST);
   assign act_wr_addr = (mode_ff == spheng_pkg::MODE_LOAD_SRC) ? spheng_pkg::ACT_AW'(row_ff)
                      : spheng_pkg::ACT_AW'(spheng_pkg::SRC_UNITS) + spheng_pkg::ACT_AW'(col_ff);

   spheng_ram #(.WIDTH(VW), .DEPTH(spheng_pkg::ACT_DEPTH)) u_act_ram (
      .clock   (clock),
      .wr_en   (act_wr_en),
      .wr_addr (act_wr_addr),
      .wr_data (w_ff),
      .rd_addr (act_rd_addr),
      .rd_data (act_rd_data)
   );

   // Each column row holds the running sum above the running total.
   assign col_wr_en   = (state_ff == ST_FIN) &&
                        (mode_ff inside {spheng_pkg::MODE_CLEAR, spheng_pkg::MODE_PROJECT,
                                         spheng_pkg::MODE_LEARN, spheng_pkg::MODE_TOTAL});
   assign col_wr_data = {new_sum_c, new_tot_c};

   spheng_ram #(.WIDTH(spheng_pkg::COL_MEM_W), .DEPTH(spheng_pkg::COL_UNITS)) u_col_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_ff),
      .wr_data (col_wr_data),
      .rd_addr (col_ff),
      .rd_data (col_rd_data)
   );

   // ---------------------------------------------------------------- gating
   assign src_low  = $signed(src_ff) < $signed({1'b0, thr_ff});
   assign dst_low  = $signed(dst_ff) < $signed({1'b0, thr_ff});
   assign skip3    = gate_en_ff && src_low;
   assign skip4    = gate_en_ff && (src_low || dst_low);
   assign skip6    = gate_en_ff && dst_low;
   assign zero6    = (tot_ff == '0);
   assign need_div = (mode_ff == spheng_pkg::MODE_NORMALIZE) && !skip6 && !zero6;

   // ---------------------------------------------------------------- multiplier
   // First step: src*w, dst*rate, or the upper half of the sum times the gain.
   // Second step: t*src, or the lower half of the sum times the gain.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL1) begin
         case (mode_ff)
            spheng_pkg::MODE_PROJECT: begin
               mul_a = spheng_pkg::MUL_W'(src_ff);
               mul_b = spheng_pkg::MUL_W'(w_ff);
            end
            spheng_pkg::MODE_LEARN: begin
               mul_a = spheng_pkg::MUL_W'(dst_ff);
               mul_b = spheng_pkg::MUL_W'(lr_ff);
            end
            spheng_pkg::MODE_READ: begin
               mul_a = spheng_pkg::MUL_W'(sum_ff >>> spheng_pkg::SPLIT);
               mul_b = spheng_pkg::MUL_W'(gain_ff);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end else begin
         case (mode_ff)
            spheng_pkg::MODE_LEARN: begin
               mul_a = spheng_pkg::MUL_W'(t_ff);
               mul_b = spheng_pkg::MUL_W'(src_ff);
            end
            spheng_pkg::MODE_READ: begin
               mul_a = $signed(spheng_pkg::MUL_W'(sum_ff[spheng_pkg::SPLIT-1:0]));
               mul_b = spheng_pkg::MUL_W'(gain_ff);
            end
            default: begin
               mul_a = '0;
               mul_b = '0;
            end
         endcase
      end
      mul_p = mul_a * mul_b;
   end

   // ---------------------------------------------------------------- divider
   assign abs_w     = w_ff[VW-1] ? VW'(-w_ff) : VW'(w_ff);
   assign abs_tot   = tot_ff[SW-1] ? SW'(-tot_ff) : SW'(tot_ff);
   assign div_num   = {abs_w, {FB{1'b0}}};
   assign div_den   = abs_tot;
   assign div_start = (state_ff == ST_MUL1) && need_div;

   spheng_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num_mag  (div_num),
      .den_mag  (div_den),
      .quotient (div_q),
      .status   (div_stat)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_RD_SRC;
         ST_RD_SRC: state_in = ST_RD_DST;
         ST_RD_DST: state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_MUL1;
         ST_MUL1:   state_in = need_div ? ST_DIV : ST_MID;
         ST_MID:    state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_FIN;
         ST_DIV:    if (div_stat.done) state_in = ST_FIN;
         ST_FIN:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_FIN);
      end
   end

   // Clamp of the learning factor sits in its own step ahead of the second product.
   assign t_wide = WW'(hi_ff >>> FB);

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         mode_ff <= req_mode;
         row_ff  <= req_row_index[spheng_pkg::SRC_AW-1:0];
         col_ff  <= req_column_index[spheng_pkg::COL_AW-1:0];
         w_ff    <= req_item_value;
      end
      if (state_ff == ST_RD_DST) begin
         src_ff <= act_rd_data;
      end
      if (state_ff == ST_LOAD) begin
         dst_ff <= act_rd_data;
         sum_ff <= col_rd_data[spheng_pkg::COL_MEM_W-1:SW];
         tot_ff <= col_rd_data[SW-1:0];
      end
      if (state_ff == ST_MUL1) begin
         hi_ff <= mul_p;
      end
      if (state_ff == ST_MID) begin
         t_ff    <= spheng_pkg::clamp_val(t_wide);
         terr_ff <= !spheng_pkg::fits_val(t_wide);
      end
      if (state_ff == ST_MUL2) begin
         lo_ff <= mul_p;
      end
      if (state_ff == ST_FIN) begin
         res_ff     <= res_c;
         tot_out_ff <= tot_c;
         app_ff     <= app_c;
         err_ff     <= err_c;
      end
   end

   // ---------------------------------------------------------------- finish step
   always_comb begin
      x3       = WW'(sum_ff) + WW'(hi_ff >>> FB);
      x4       = WW'(w_ff) + WW'(lo_ff >>> FB);
      nw       = skip4 ? w_ff : spheng_pkg::clamp_val(x4);
      tot4     = WW'(tot_ff) + WW'(nw);
      x5       = WW'(tot_ff) + WW'(w_ff);
      x7       = ((WW'(hi_ff) <<< spheng_pkg::SPLIT) + WW'(lo_ff)) >>> FB;
      q_signed = (w_ff[VW-1] ^ tot_ff[SW-1]) ? -$signed({1'b0, div_q})
                                             : $signed({1'b0, div_q});
      x6       = WW'(q_signed);

      res_c     = w_ff;
      tot_c     = tot_ff;
      app_c     = 1'b1;
      err_c     = 1'b0;
      new_sum_c = sum_ff;
      new_tot_c = tot_ff;
      unique case (mode_ff) inside
         spheng_pkg::MODE_LOAD_SRC, spheng_pkg::MODE_LOAD_DST: begin
            tot_c = '0;
         end
         spheng_pkg::MODE_CLEAR: begin
            res_c     = '0;
            tot_c     = '0;
            new_sum_c = '0;
            new_tot_c = '0;
         end
         spheng_pkg::MODE_PROJECT: begin
            if (skip3) begin
               app_c = 1'b0;
            end else begin
               new_sum_c = spheng_pkg::clamp_sum(x3);
               err_c     = !spheng_pkg::fits_sum(x3);
            end
         end
         spheng_pkg::MODE_LEARN: begin
            // A gated update still adds the unchanged weight to the total.
            res_c     = nw;
            new_tot_c = spheng_pkg::clamp_sum(tot4);
            tot_c     = new_tot_c;
            app_c     = !skip4;
            err_c     = (!skip4 && (terr_ff || !spheng_pkg::fits_val(x4))) ||
                        !spheng_pkg::fits_sum(tot4);
         end
         spheng_pkg::MODE_TOTAL: begin
            new_tot_c = spheng_pkg::clamp_sum(x5);
            tot_c     = new_tot_c;
            err_c     = !spheng_pkg::fits_sum(x5);
         end
         spheng_pkg::MODE_NORMALIZE: begin
            if (skip6) begin
               app_c = 1'b0;
            end else if (zero6) begin
               app_c = 1'b0;
               err_c = 1'b1;
            end else begin
               res_c = spheng_pkg::clamp_val(x6);
               err_c = !spheng_pkg::fits_val(x6);
            end
         end
         spheng_pkg::MODE_READ: begin
            res_c = spheng_pkg::clamp_val(x7);
            err_c = !spheng_pkg::fits_val(x7);
         end
         default: begin
            app_c = 1'b1;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_total_value  = tot_out_ff;
   assign rsp_applied      = app_ff;
   assign rsp_error_flag   = err_ff;

   // ---------------------------------------------------------------- assertions
   `SPHENG_ASSERT_IMP(a_rsp_from_fin, clock, reset, rsp_valid_ff, $past(state_ff) == ST_FIN, "response strobe without a finish step")
   `SPHENG_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy && !rsp_valid_ff, "accepted beat did not start the sequencer")
   `SPHENG_ASSERT_IMP(a_div_done_in_div, clock, reset, div_stat.done, state_ff == ST_DIV, "divider finished outside the divide state")
   `SPHENG_ASSERT_IMP(a_div_busy_in_div, clock, reset, div_stat.busy, state_ff == ST_DIV, "divider running outside the divide state")

endmodule
